FILE: hdl/arp_cache_engine_macros.svh
// assertion helpers for the ARP cache engine
`ifndef ARP_CACHE_ENGINE_MACROS_SVH
`define ARP_CACHE_ENGINE_MACROS_SVH

`define ACE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ACE_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/ace_pkg.sv
`timescale 1ns / 1ps
package ace_pkg;
   localparam int FUNC_W   = 2;
   localparam int OUTC_W   = 3;
   localparam int MAC_W    = 48;
   localparam int IP_W     = 32;
   localparam int TICK_W   = 32;
   localparam int CNT_OUT_W = 5;
   localparam int REQ_DATA_W = 224;
   localparam int RSP_DATA_W = 168;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 48;
   localparam logic [15:0] ARP_LEN    = 16'd28;
   localparam logic [15:0] OP_REQUEST = 16'd1;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd1000;

   typedef enum logic [FUNC_W-1:0] {
      FN_PACKET = 2'd0,
      FN_LEARN  = 2'd1,
      FN_LOOKUP = 2'd2,
      FN_TICK   = 2'd3
   } func_type;

   typedef enum logic [OUTC_W-1:0] {
      OC_NONE      = 3'd0,
      OC_REFRESHED = 3'd1,
      OC_LEARNED   = 3'd2,
      OC_CONTRA    = 3'd3,
      OC_FULL      = 3'd4,
      OC_BAD_SIZE  = 3'd5,
      OC_MISMATCH  = 3'd6
   } outcome_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OWN_IP       = 8'd0,
      REG_OWN_IP_VALID = 8'd1,
      REG_OWN_MAC      = 8'd2,
      REG_TIMEOUT      = 8'd3
   } csr_reg_type;
endpackage

FILE: hdl/arp_cache_engine.sv
// Learn, lookup and well-formed packets make one pass over the entry memory; tick and
// rejected packets skip the scan. The engine takes one item at a time; the scan of
// the one-port entry RAM sets the rate.
// Reset (synchronous, active high) clears slot valid and disputed bits, tick,
// contradiction count and registers; the entry RAM itself needs no clearing.
`timescale 1ns / 1ps
module arp_cache_engine
   import ace_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // packet_length, opcode, arp_sha, arp_spa, arp_tpa, frame_src_mac, query_ip
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // reply_valid, reply_mac, reply_ip, hit, hit_mac, hit_disputed, entry_count,
   // contradiction_total
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // outcome
   output logic [OUTC_W-1:0]     rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int ENT_W = IP_W + MAC_W + TICK_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_SPARE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [IP_W-1:0]   own_ip_ff;
   logic              own_ip_valid_ff;
   logic [MAC_W-1:0]  own_mac_ff;
   logic [TICK_W-1:0] timeout_ff;

   logic [ENTRIES-1:0] used_ff, disp_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [TICK_W-1:0]  tick_ff;
   logic [31:0]        tally_ff;

   logic [ENT_W-1:0] mem [ENTRIES];
   logic [ENT_W-1:0] rd_data_ff;

   func_type          func_ff;
   logic [IP_W-1:0]   key_ff;
   logic [MAC_W-1:0]  mac_ff;
   logic              reply_ff;
   outcome_type       early_ff;
   logic              scanned_ff;

   logic [CNT_W-1:0]  rd_cnt_ff;
   logic              chk_valid_ff;
   logic [IDX_W-1:0]  chk_idx_ff;
   logic              found_ff, free_ff;
   logic [IDX_W-1:0]  found_idx_ff, free_idx_ff;
   logic [MAC_W-1:0]  found_mac_ff;

   logic              out_valid_ff;
   outcome_type       out_oc_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;

   logic [15:0]       in_plen, in_op;
   logic [MAC_W-1:0]  in_smac, in_fmac;
   logic [IP_W-1:0]   in_sip, in_tip, in_qip;
   logic              accept, out_free, finish_go;

   assign in_plen = req_tdata[15:0];
   assign in_op   = req_tdata[31:16];
   assign in_smac = req_tdata[79:32];
   assign in_sip  = req_tdata[111:80];
   assign in_tip  = req_tdata[143:112];
   assign in_fmac = req_tdata[191:144];
   assign in_qip  = req_tdata[223:192];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign finish_go  = (state_ff == ST_FINISH) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff       <= '0;
         own_ip_valid_ff <= 1'b0;
         own_mac_ff      <= '0;
         timeout_ff      <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_OWN_IP:       own_ip_ff       <= csr_wdata[IP_W-1:0];
            REG_OWN_IP_VALID: own_ip_valid_ff <= csr_wdata[0];
            REG_OWN_MAC:      own_mac_ff      <= csr_wdata[MAC_W-1:0];
            REG_TIMEOUT:      timeout_ff      <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= func_type'(req_tuser);
         key_ff   <= (func_type'(req_tuser) == FN_LOOKUP) ? in_qip : in_sip;
         mac_ff   <= in_smac;
         reply_ff <= (func_type'(req_tuser) == FN_PACKET)
                     && (in_op == OP_REQUEST) && own_ip_valid_ff && (in_tip == own_ip_ff)
                     && (in_plen == ARP_LEN) && (in_smac == in_fmac);
         early_ff <= (in_plen != ARP_LEN) ? OC_BAD_SIZE : OC_MISMATCH;
      end
   end

   logic scan_start;
   assign scan_start = accept && ((func_type'(req_tuser) == FN_LEARN)
      || (func_type'(req_tuser) == FN_LOOKUP)
      || ((func_type'(req_tuser) == FN_PACKET) && (in_plen == ARP_LEN)
          && (in_smac == in_fmac)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = scan_start ? ST_SCAN : ST_FINISH;
         ST_SCAN:   if (chk_valid_ff && (chk_idx_ff == IDX_W'(ENTRIES - 1)))
                       state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // scan: read issue, and check in the following cycle
   logic issue;
   assign issue = (state_ff == ST_SCAN) && (rd_cnt_ff < CNT_W'(ENTRIES));

   always_ff @(posedge clock) begin
      if (issue) rd_data_ff <= mem[rd_cnt_ff[IDX_W-1:0]];
   end

   logic [IP_W-1:0]   e_ip;
   logic [MAC_W-1:0]  e_mac;
   logic [TICK_W-1:0] e_seen, age;
   logic              is_learn, c_used, c_stale, c_eff;
   assign e_seen   = rd_data_ff[TICK_W-1:0];
   assign e_mac    = rd_data_ff[TICK_W+MAC_W-1:TICK_W];
   assign e_ip     = rd_data_ff[ENT_W-1:TICK_W+MAC_W];
   assign age      = tick_ff - e_seen;
   assign is_learn = (func_ff != FN_LOOKUP);
   assign c_used   = used_ff[chk_idx_ff];
   assign c_stale  = chk_valid_ff && is_learn && c_used && (age > timeout_ff);
   assign c_eff    = c_used && !c_stale;

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
      end else begin
         chk_valid_ff <= issue;
      end
      if (accept) begin
         rd_cnt_ff <= '0;
         found_ff  <= 1'b0;
         free_ff   <= 1'b0;
      end else begin
         if (issue) rd_cnt_ff <= rd_cnt_ff + 1'b1;
         if (chk_valid_ff) begin
            if (c_eff && (e_ip == key_ff) && !found_ff) begin
               found_ff     <= 1'b1;
               found_idx_ff <= chk_idx_ff;
               found_mac_ff <= e_mac;
            end
            if (!c_eff && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= chk_idx_ff;
            end
         end
      end
      chk_idx_ff <= rd_cnt_ff[IDX_W-1:0];
   end

   // finish: decide, write back, build result
   outcome_type       oc;
   logic              do_wr, do_new, do_contra;
   logic [IDX_W-1:0]  wr_idx;
   logic [CNT_W-1:0]  count_fin;
   logic              hit, hit_disp;
   logic [MAC_W-1:0]  hit_mac;
   logic [CNT_W+CNT_OUT_W-1:0] count_ext;
   logic [31:0]       tally_fin;

   always_comb begin
      oc = OC_NONE;
      do_wr = 1'b0;
      do_new = 1'b0;
      do_contra = 1'b0;
      wr_idx = found_idx_ff;
      hit = 1'b0;
      hit_mac = '0;
      hit_disp = 1'b0;
      unique case (func_ff)
         FN_PACKET, FN_LEARN: begin
            if ((func_ff == FN_PACKET) && (state_ff == ST_FINISH) && !scanned_ff) begin
               oc = early_ff;
            end else if (found_ff) begin
               if (found_mac_ff != mac_ff) begin
                  oc = OC_CONTRA;
                  do_contra = 1'b1;
               end else begin
                  oc = OC_REFRESHED;
                  do_wr = 1'b1;
               end
            end else if (free_ff) begin
               oc = OC_LEARNED;
               do_wr = 1'b1;
               do_new = 1'b1;
               wr_idx = free_idx_ff;
            end else begin
               oc = OC_FULL;
            end
         end
         FN_LOOKUP: begin
            hit = found_ff;
            if (found_ff) begin
               hit_mac  = found_mac_ff;
               hit_disp = disp_ff[found_idx_ff];
            end
         end
         default: ;
      endcase
      count_fin = count_ff + CNT_W'(do_new);
      tally_fin = tally_ff + 32'(do_contra);
      count_ext = {{CNT_OUT_W{1'b0}}, count_fin};
   end

   always_ff @(posedge clock) begin
      if (reset)                          scanned_ff <= 1'b0;
      else if (accept)                    scanned_ff <= scan_start;
   end

   always_ff @(posedge clock) begin
      if (finish_go && do_wr) mem[wr_idx] <= {key_ff, mac_ff, tick_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         disp_ff  <= '0;
         count_ff <= '0;
         tick_ff  <= '0;
         tally_ff <= '0;
      end else begin
         if (c_stale) begin
            used_ff[chk_idx_ff] <= 1'b0;
            disp_ff[chk_idx_ff] <= 1'b0;
            count_ff <= count_ff - 1'b1;
         end
         if (finish_go) begin
            count_ff <= count_fin;
            tally_ff <= tally_fin;
            if (do_new) begin
               used_ff[wr_idx] <= 1'b1;
               disp_ff[wr_idx] <= 1'b0;
            end
            if (do_contra) disp_ff[found_idx_ff] <= 1'b1;
            if (func_ff == FN_TICK) tick_ff <= tick_ff + 1'b1;
         end
      end
   end

   logic [RSP_DATA_W-1:0] res_data;
   always_comb begin
      res_data = {tally_fin, count_ext[CNT_OUT_W-1:0], hit_disp, hit_mac, hit,
                  reply_ff ? key_ff : {IP_W{1'b0}},
                  reply_ff ? mac_ff : {MAC_W{1'b0}},
                  reply_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (finish_go) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (finish_go) begin
         out_oc_ff   <= oc;
         out_data_ff <= res_data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_oc_ff;
endmodule

FILE: hdl/ace_checker.sv
`timescale 1ns / 1ps
`include "arp_cache_engine_macros.svh"
module ace_checker
   import ace_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [OUTC_W-1:0]     rsp_tuser
);
   `ACE_ASSERT_RST(a_rst_idle, clock, reset |=> !rsp_tvalid, "result after reset")
   `ACE_ASSERT(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "result moved while stalled")
   `ACE_ASSERT(a_oc_range, clock, reset, rsp_tvalid |-> rsp_tuser != 3'd7, "outcome out of range")
   `ACE_ASSERT(a_reply_oc, clock, reset, rsp_tvalid && rsp_tdata[0] |-> (rsp_tuser == OC_REFRESHED || rsp_tuser == OC_LEARNED || rsp_tuser == OC_CONTRA || rsp_tuser == OC_FULL), "reply without learn")
   `ACE_ASSERT(a_hit_miss, clock, reset, rsp_tvalid && !rsp_tdata[81] |-> rsp_tdata[129:82] == 48'd0 && !rsp_tdata[130], "hit fields on miss")
endmodule

bind arp_cache_engine ace_checker u_ace_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/arp_cache_engine_tb.sv
`timescale 1ns / 1ps
module arp_cache_engine_tb
   import ace_pkg::*;
;

   localparam int NSLOT = 16;
   localparam int SETTLE = NSLOT + 8;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 8'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 8'd255;
   localparam int NDIR = 16;
   localparam int NPHASE_ITEMS = 175;

   typedef struct {
      func_type    fn;
      logic [15:0] plen;
      logic [15:0] opc;
      logic [47:0] smac;
      logic [31:0] sip;
      logic [31:0] tip;
      logic [47:0] fmac;
      logic [31:0] qip;
   } arp_item_type;

   typedef struct {
      outcome_type oc;
      logic        rv;
      logic [47:0] rmac;
      logic [31:0] rip;
      logic        hit;
      logic [47:0] hmac;
      logic        hd;
      logic [4:0]  cnt;
      logic [31:0] ctot;
   } arp_rsp_type;

   typedef struct {
      arp_item_type it;
      logic         chk;
      outcome_type  oc;
   } dir_row_type;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [OUTC_W-1:0]     rsp_tuser;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   arp_cache_engine #(.ENTRIES(NSLOT)) dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // cache model
   logic        c_used [NSLOT];
   logic        c_disp [NSLOT];
   logic [31:0] c_ip [NSLOT];
   logic [47:0] c_mac [NSLOT];
   logic [31:0] c_seen [NSLOT];
   logic [31:0] c_tick = 0;
   logic [31:0] c_contra = 0;
   logic [31:0] r_own_ip = 0;
   logic        r_own_valid = 0;
   logic [47:0] r_own_mac = 0;
   logic [31:0] r_timeout = TIMEOUT_RESET;

   arp_rsp_type rsp_expected[$];
   logic        rsp_typed_chk[$];
   outcome_type rsp_typed_oc[$];
   int errors = 0;
   int n_sent = 0;
   int n_rsp = 0;
   int n_replies = 0;
   int n_full = 0;
   int n_csr = 0;

   logic        cur_chk = 0;
   outcome_type cur_oc = OC_NONE;
   int burst_left = 0;

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         c_used[i] = 0; c_disp[i] = 0; c_ip[i] = 0; c_mac[i] = 0; c_seen[i] = 0;
      end
   end

   function automatic int slot_find(logic [31:0] ip);
      for (int i = 0; i < NSLOT; i++)
         if (c_used[i] && c_ip[i] == ip) return i;
      return -1;
   endfunction

   function automatic outcome_type cache_learn(logic [31:0] ip, logic [47:0] mac);
      int k;
      for (int i = 0; i < NSLOT; i++)
         if (c_used[i] && (c_tick - c_seen[i]) > r_timeout) begin
            c_used[i] = 0;
            c_disp[i] = 0;
         end
      k = slot_find(ip);
      if (k >= 0) begin
         if (c_mac[k] != mac) begin
            c_contra = c_contra + 1;
            c_disp[k] = 1;
            return OC_CONTRA;
         end
         c_seen[k] = c_tick;
         return OC_REFRESHED;
      end
      for (int i = 0; i < NSLOT; i++)
         if (!c_used[i]) begin
            c_ip[i] = ip; c_mac[i] = mac; c_seen[i] = c_tick;
            c_used[i] = 1; c_disp[i] = 0;
            return OC_LEARNED;
         end
      return OC_FULL;
   endfunction

   function automatic arp_rsp_type cache_predict(arp_item_type it);
      arp_rsp_type r;
      int k;
      int n;
      r = '{oc: OC_NONE, rv: 0, rmac: 0, rip: 0, hit: 0, hmac: 0, hd: 0, cnt: 0, ctot: 0};
      case (it.fn)
         FN_PACKET: begin
            if (it.plen != ARP_LEN) r.oc = OC_BAD_SIZE;
            else if (it.smac != it.fmac) r.oc = OC_MISMATCH;
            else begin
               r.oc = cache_learn(it.sip, it.smac);
               if (it.opc == OP_REQUEST && r_own_valid && it.tip == r_own_ip) begin
                  r.rv = 1; r.rmac = it.smac; r.rip = it.sip;
               end
            end
         end
         FN_LEARN: r.oc = cache_learn(it.sip, it.smac);
         FN_LOOKUP: begin
            k = slot_find(it.qip);
            if (k >= 0) begin
               r.hit = 1; r.hmac = c_mac[k]; r.hd = c_disp[k];
            end
         end
         default: c_tick = c_tick + 1;
      endcase
      n = 0;
      for (int i = 0; i < NSLOT; i++) if (c_used[i]) n++;
      r.cnt = n[4:0];
      r.ctot = c_contra;
      return r;
   endfunction

   // monitor: results first, then accepted requests and register writes
   always @(posedge clock) begin
      arp_rsp_type a;
      arp_rsp_type e;
      logic tc;
      outcome_type to;
      arp_item_type it;
      if (rsp_tvalid && rsp_tready) begin
         a.oc = outcome_type'(rsp_tuser);
         a.rv = rsp_tdata[0];
         a.rmac = rsp_tdata[48:1];
         a.rip = rsp_tdata[80:49];
         a.hit = rsp_tdata[81];
         a.hmac = rsp_tdata[129:82];
         a.hd = rsp_tdata[130];
         a.cnt = rsp_tdata[135:131];
         a.ctot = rsp_tdata[167:136];
         n_rsp++;
         if (rsp_expected.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transfer on result channel");
         end else begin
            e = rsp_expected.pop_front();
            tc = rsp_typed_chk.pop_front();
            to = rsp_typed_oc.pop_front();
            if (a.rv) n_replies++;
            if (a.oc == OC_FULL) n_full++;
            if (a.oc !== e.oc || a.rv !== e.rv || a.rmac !== e.rmac || a.rip !== e.rip ||
                a.hit !== e.hit || a.hmac !== e.hmac || a.hd !== e.hd ||
                a.cnt !== e.cnt || a.ctot !== e.ctot || (tc && a.oc !== to)) begin
               errors++;
               if (errors <= 10) begin
                  $display("result %0d mismatch: exp oc=%0d rv=%0d rmac=%h rip=%h hit=%0d",
                           n_rsp, e.oc, e.rv, e.rmac, e.rip, e.hit);
                  $display("   hmac=%h hd=%0d cnt=%0d ctot=%0d (table oc %0d/%0d)",
                           e.hmac, e.hd, e.cnt, e.ctot, tc, to);
                  $display("   got oc=%0d rv=%0d rmac=%h rip=%h hit=%0d hmac=%h hd=%0d",
                           a.oc, a.rv, a.rmac, a.rip, a.hit, a.hmac, a.hd);
                  $display("   cnt=%0d ctot=%0d", a.cnt, a.ctot);
               end
            end
         end
      end
      if (req_tvalid && req_tready) begin
         it.fn = func_type'(req_tuser);
         it.plen = req_tdata[15:0];
         it.opc = req_tdata[31:16];
         it.smac = req_tdata[79:32];
         it.sip = req_tdata[111:80];
         it.tip = req_tdata[143:112];
         it.fmac = req_tdata[191:144];
         it.qip = req_tdata[223:192];
         rsp_expected.push_back(cache_predict(it));
         rsp_typed_chk.push_back(cur_chk);
         rsp_typed_oc.push_back(cur_oc);
      end
      if (csr_valid && csr_ready) begin
         n_csr++;
         case (csr_index)
            REG_OWN_IP:       r_own_ip = csr_wdata[31:0];
            REG_OWN_IP_VALID: r_own_valid = csr_wdata[0];
            REG_OWN_MAC:      r_own_mac = csr_wdata;
            REG_TIMEOUT:      r_timeout = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // receiver: changing stall pattern, one long hold-off
   initial begin
      int cyc;
      int mode;
      logic rdy;
      cyc = 0;
      mode = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         cyc++;
         if (cyc % 60 == 0) mode = $urandom_range(0, 2);
         if (cyc >= 3000 && cyc < 3500) rdy = 0;
         else if (mode == 0) rdy = 1;
         else if (mode == 1) rdy = ($urandom_range(0, 1) == 1);
         else rdy = ($urandom_range(0, 3) == 0);
         rsp_tready <= rdy;
         @(negedge clock);
      end
   end

   task automatic send_item(arp_item_type it, logic chk, outcome_type oc);
      int gap;
      req_tvalid <= 1;
      req_tuser <= it.fn;
      req_tdata <= {it.qip, it.fmac, it.tip, it.sip, it.smac, it.opc, it.plen};
      cur_chk <= chk;
      cur_oc <= oc;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_sent++;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      @(negedge clock);
      while (rsp_expected.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic arp_item_type rand_item();
      arp_item_type it;
      int f;
      logic [31:0] ip;
      logic [47:0] mac;
      it.fn = FN_PACKET;
      it.plen = 16'($urandom); it.opc = 16'($urandom);
      it.smac = 48'({$urandom, $urandom}); it.sip = $urandom; it.tip = $urandom;
      it.fmac = 48'({$urandom, $urandom}); it.qip = $urandom;
      if ($urandom_range(0, 9) == 0) ip = $urandom;
      else ip = 32'hC0A80000 | $urandom_range(0, 23);
      mac = {8'h02, 7'h0, ($urandom_range(0, 5) == 0), ip};
      f = $urandom_range(0, 99);
      if (f < 40) begin
         it.fn = FN_PACKET;
         it.sip = ip; it.smac = mac; it.fmac = mac;
         if ($urandom_range(0, 11) != 0) it.plen = ARP_LEN;
         if ($urandom_range(0, 9) == 0) it.fmac = 48'({$urandom, $urandom});
         f = $urandom_range(0, 9);
         if (f < 5) it.opc = OP_REQUEST;
         else if (f < 9) it.opc = 16'd2;
         if ($urandom_range(0, 2) == 0) it.tip = r_own_ip;
      end else if (f < 60) begin
         it.fn = FN_LEARN;
         it.sip = ip; it.smac = mac;
      end else if (f < 85) begin
         it.fn = FN_LOOKUP;
         it.qip = ip;
      end else begin
         it.fn = FN_TICK;
      end
      return it;
   endfunction

   function automatic arp_item_type mk(func_type fn, logic [15:0] plen, logic [15:0] opc,
                                       logic [47:0] smac, logic [31:0] sip,
                                       logic [31:0] tip, logic [47:0] fmac,
                                       logic [31:0] qip);
      arp_item_type it;
      it = '{fn: fn, plen: plen, opc: opc, smac: smac, sip: sip, tip: tip,
             fmac: fmac, qip: qip};
      return it;
   endfunction

   dir_row_type dir_tab [NDIR];

   initial begin
      dir_tab[0]  = '{mk(FN_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 1, OC_NONE};
      dir_tab[1]  = '{mk(FN_PACKET, 16'd0, OP_REQUEST, 48'h1, 32'h1, 0, 48'h1, 0), 1, OC_BAD_SIZE};
      dir_tab[2]  = '{mk(FN_PACKET, 16'hFFFF, 16'hFFFF, '1, '1, '1, '1, '1), 1, OC_BAD_SIZE};
      dir_tab[3]  = '{mk(FN_PACKET, ARP_LEN, OP_REQUEST, 48'h5, 32'h5, 0, 48'h6, 0), 1,
                      OC_MISMATCH};
      dir_tab[4]  = '{mk(FN_LEARN, 0, 0, 48'h0, 32'h0, 0, 0, 0), 1, OC_LEARNED};
      dir_tab[5]  = '{mk(FN_LEARN, 0, 0, '1, '1, 0, 0, 0), 1, OC_LEARNED};
      dir_tab[6]  = '{mk(FN_LEARN, 0, 0, '1, '1, 0, 0, 0), 1, OC_REFRESHED};
      dir_tab[7]  = '{mk(FN_LEARN, 0, 0, 48'h0A0B0C0D0E0F, '1, 0, 0, 0), 1, OC_CONTRA};
      dir_tab[8]  = '{mk(FN_LOOKUP, 0, 0, 0, 0, 0, 0, '1), 0, OC_NONE};
      dir_tab[9]  = '{mk(FN_PACKET, ARP_LEN, OP_REQUEST, 48'h77, 32'h7, 32'h0, 48'h77, 0), 0,
                      OC_NONE};
      dir_tab[10] = '{mk(FN_TICK, 0, 0, 0, 0, 0, 0, 0), 1, OC_NONE};
      dir_tab[11] = '{mk(FN_LEARN, 0, 0, '1, '1, 0, 0, 0), 1, OC_REFRESHED};
      dir_tab[12] = '{mk(FN_LOOKUP, 0, 0, 0, 0, 0, 0, '1), 0, OC_NONE};
      dir_tab[13] = '{mk(FN_PACKET, ARP_LEN, 16'd2, 48'h77, 32'h7, 32'h0, 48'h77, 0), 0,
                      OC_NONE};
      dir_tab[14] = '{mk(FN_LOOKUP, 0, 0, 0, 0, 0, 0, 32'h7), 0, OC_NONE};
      dir_tab[15] = '{mk(FN_LOOKUP, 0, 0, 0, 0, 0, 0, 32'h12345678), 0, OC_NONE};
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      for (int i = 0; i < NDIR; i++) send_item(dir_tab[i].it, dir_tab[i].chk, dir_tab[i].oc);
      for (int ph = 0; ph < 4; ph++) begin
         wait_idle();
         case (ph)
            0: begin
               write_reg(REG_OWN_IP, 48'h0000C0A80005);
               write_reg(REG_OWN_IP_VALID, 48'h1);
               write_reg(REG_OWN_MAC, 48'h02AABBCCDDEE);
               write_reg(REG_TIMEOUT, 48'd3);
            end
            1: begin
               write_reg(REG_TIMEOUT, 48'd0);
               write_reg(REG_OWN_IP, 48'hFFFF_FFFF_FFFF);
               write_reg(REG_SPARE_LO, '1);
            end
            2: begin
               write_reg(REG_TIMEOUT, 48'h0000FFFFFFFF);
               write_reg(REG_OWN_MAC, '1);
               write_reg(REG_OWN_IP, 48'h0000C0A80011);
               write_reg(REG_SPARE_HI, 48'h0);
            end
            default: begin
               write_reg(REG_OWN_IP_VALID, 48'h0);
               write_reg(REG_TIMEOUT, 48'd1000);
               write_reg(REG_OWN_MAC, 48'h0);
            end
         endcase
         for (int i = 0; i < NPHASE_ITEMS; i++) send_item(rand_item(), 0, OC_NONE);
      end
      req_tvalid <= 0;
      while (rsp_expected.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (rsp_expected.size() != 0) errors++;
      $display("%0d requests, %0d results, %0d register writes over four settings", n_sent,
               n_rsp, n_csr);
      $display("%0d replies, %0d table-full results, %0d mismatches", n_replies, n_full,
               errors);
      if (errors == 0) $display("[arp_cache_engine] OK");
      else $display("[arp_cache_engine] ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("[arp_cache_engine] ERROR");
      $finish;
   end
endmodule
